// File: design/nearest_point_search_macros.svh
// ----------------------------------------------------------------------------
// Nearest point search assertion macros
// Shared concurrent assertion forms for the nearest point search design.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/nps_pkg.sv
// ----------------------------------------------------------------------------
// Nearest point search package
// Shared widths, defaults, codes and types of the nearest point search block.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

    // Fixed field widths of the stream words.
    localparam int POS_W       = 16;
    localparam int S_TDATA_W   = 3 * POS_W;
    localparam int S_TUSER_W   = 1;
    localparam int IDX_OUT_W   = 8;
    localparam int M_TDATA_W   = IDX_OUT_W;
    localparam int M_TUSER_W   = 2;

    // Defaults of the top level parameters.
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    // Item kinds carried in the input tuser.
    typedef enum logic {
        KIND_ADD   = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } t_state;

    // Control that travels with each point through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

`default_nettype wire

// File: design/nps_dist.sv
// ----------------------------------------------------------------------------
// Nearest point search distance pipeline
// Three-stage squared Euclidean distance between a stored point and the query.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_dist #(
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
    parameter int IDX_W      = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire nps_pkg::t_ctl             i_ctl,
    input  wire logic [IDX_W-1:0]          i_idx,
    input  wire logic [COORD_BITS-1:0]     i_pt_x,
    input  wire logic [COORD_BITS-1:0]     i_pt_y,
    input  wire logic [COORD_BITS-1:0]     i_pt_z,
    input  wire logic [COORD_BITS-1:0]     i_q_x,
    input  wire logic [COORD_BITS-1:0]     i_q_y,
    input  wire logic [COORD_BITS-1:0]     i_q_z,
    output nps_pkg::t_ctl                  o_ctl,
    output logic [IDX_W-1:0]               o_idx,
    output logic [2*COORD_BITS+1:0]        o_dist
);
    import nps_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 2;

    logic signed [COORD_BITS:0] d_x, d_y, d_z;
    logic [COORD_BITS-1:0]      a_x, a_y, a_z;

    logic [COORD_BITS-1:0] r_ax, r_ay, r_az;
    logic [SQ_W-1:0]       r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]     r_dist;
    t_ctl                  r_c1, r_c2, r_c3;
    logic [IDX_W-1:0]      r_i1, r_i2, r_i3;

    // Signed differences one bit wider than a coordinate, then magnitudes.
    // The magnitude of a difference never exceeds 2^COORD_BITS - 1.
    always_comb begin
        d_x = $signed({i_pt_x[COORD_BITS-1], i_pt_x}) - $signed({i_q_x[COORD_BITS-1], i_q_x});
        d_y = $signed({i_pt_y[COORD_BITS-1], i_pt_y}) - $signed({i_q_y[COORD_BITS-1], i_q_y});
        d_z = $signed({i_pt_z[COORD_BITS-1], i_pt_z}) - $signed({i_q_z[COORD_BITS-1], i_q_z});
        a_x = d_x[COORD_BITS] ? COORD_BITS'(-d_x) : COORD_BITS'(d_x);
        a_y = d_y[COORD_BITS] ? COORD_BITS'(-d_y) : COORD_BITS'(d_y);
        a_z = d_z[COORD_BITS] ? COORD_BITS'(-d_z) : COORD_BITS'(d_z);
    end

    // Control flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            r_c1 <= i_ctl;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    // Datapath: magnitudes, one squarer per axis, then the sum.
    always_ff @(posedge i_clk) begin
        r_ax   <= a_x;
        r_ay   <= a_y;
        r_az   <= a_z;
        r_i1   <= i_idx;
        r_sx   <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy   <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_sz   <= SQ_W'(r_az) * SQ_W'(r_az);
        r_i2   <= r_i1;
        r_dist <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        r_i3   <= r_i2;
    end

    assign o_ctl  = r_c3;
    assign o_idx  = r_i3;
    assign o_dist = r_dist;

endmodule

`default_nettype wire

// File: design/nearest_point_search.sv
// An accepted add writes its result into the output register in the next cycle.
// A query over N stored points issues one memory read a cycle, then passes
// through the registered read and a three-stage distance pipeline before compare.
// An empty-table query answers in the next cycle. Items are handled one at a time.
// Reset empties the table (count to zero); point memory contents are not cleared.
// ----------------------------------------------------------------------------
// Nearest point search
// Point table with linear nearest neighbor search over squared distances.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_point_search_macros.svh"

module nearest_point_search #(
    parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    input  wire logic [nps_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind [0]
    input  wire logic [nps_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // point_index [7:0]
    output logic [nps_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,
    // found [0], rejected [1]
    output logic [nps_pkg::M_TUSER_W-1:0]      o_m_axis_tuser
);
    import nps_pkg::*;

    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int PT_W      = 3 * COORD_BITS;
    localparam int DIST_W    = 2 * COORD_BITS + 2;
    localparam int EXT_W     = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
    localparam int IDX_EXT_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;

    // Point memory, one word holds x, y and z.
    logic [PT_W-1:0]       r_mem [MAX_POINTS];
    logic [PT_W-1:0]       r_rd_data;
    t_ctl                  r_rd_ctl;
    logic [IDX_W-1:0]      r_rd_idx;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_addr;
    logic [COORD_BITS-1:0] r_qx, r_qy, r_qz;
    logic [DIST_W-1:0]     r_best;
    logic [IDX_W-1:0]      r_best_idx;
    logic                  r_out_vld;
    logic [IDX_OUT_W-1:0]  r_out_idx;
    logic                  r_out_found;
    logic                  r_out_rej;

    logic                  in_acc;
    t_kind                 in_kind;
    logic [EXT_W-1:0]      ext_x, ext_y, ext_z;
    logic [COORD_BITS-1:0] in_x, in_y, in_z;
    logic                  table_full;
    logic                  add_ok;
    logic [IDX_W-1:0]      last_addr;
    logic                  issue;
    logic                  issue_last;
    t_ctl                  d_ctl;
    logic [IDX_W-1:0]      d_idx;
    logic [DIST_W-1:0]     d_dist;
    logic                  take;
    logic [IDX_W-1:0]      cur_best_idx;
    logic [IDX_EXT_W-1:0]  idx_ext;

    // Input word decode; only the low COORD_BITS of each coordinate count.
    always_comb begin
        in_kind = t_kind'(i_s_axis_tuser[0]);
        ext_x   = EXT_W'(i_s_axis_tdata[POS_W-1:0]);
        ext_y   = EXT_W'(i_s_axis_tdata[2*POS_W-1:POS_W]);
        ext_z   = EXT_W'(i_s_axis_tdata[3*POS_W-1:2*POS_W]);
        in_x    = ext_x[COORD_BITS-1:0];
        in_y    = ext_y[COORD_BITS-1:0];
        in_z    = ext_z[COORD_BITS-1:0];
    end

    // Handshake and table status.
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign table_full      = (r_count >= CNT_W'(MAX_POINTS));
    assign add_ok          = in_acc && (in_kind == KIND_ADD) && !table_full;
    assign last_addr       = IDX_W'(r_count - CNT_W'(1));
    assign issue           = (r_state == ST_SCAN);
    assign issue_last      = issue && (r_addr == last_addr);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_kind == KIND_QUERY) && (r_count != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (d_ctl.valid && d_ctl.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and point count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (add_ok) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Scan address and captured query point.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_addr <= '0;
            r_qx   <= in_x;
            r_qy   <= in_y;
            r_qz   <= in_z;
        end else if (issue) begin
            r_addr <= r_addr + IDX_W'(1);
        end
    end

    // Point memory: write on add, registered read during a scan.
    always_ff @(posedge i_clk) begin
        if (add_ok) begin
            r_mem[r_count[IDX_W-1:0]] <= {in_z, in_y, in_x};
        end
        r_rd_data <= r_mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    // Read control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.valid <= issue;
            r_rd_ctl.last  <= issue_last;
        end
    end

    nps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_idx   (r_rd_idx),
        .i_pt_x  (r_rd_data[COORD_BITS-1:0]),
        .i_pt_y  (r_rd_data[2*COORD_BITS-1:COORD_BITS]),
        .i_pt_z  (r_rd_data[3*COORD_BITS-1:2*COORD_BITS]),
        .i_q_x   (r_qx),
        .i_q_y   (r_qy),
        .i_q_z   (r_qz),
        .o_ctl   (d_ctl),
        .o_idx   (d_idx),
        .o_dist  (d_dist)
    );

    // Strict compare keeps the lower index on ties; the first point is always taken.
    always_comb begin
        take         = d_ctl.valid && ((d_idx == '0) || (d_dist < r_best));
        cur_best_idx = take ? d_idx : r_best_idx;
        idx_ext      = IDX_EXT_W'(cur_best_idx);
    end

    // Running minimum.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best     <= d_dist;
            r_best_idx <= d_idx;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((in_acc && ((in_kind == KIND_ADD) || (r_count == '0)))
                     || (d_ctl.valid && d_ctl.last)) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register: result word.
    always_ff @(posedge i_clk) begin
        logic [IDX_EXT_W-1:0] cnt_ext;
        cnt_ext = IDX_EXT_W'(r_count[IDX_W-1:0]);
        if (in_acc) begin
            if (in_kind == KIND_ADD) begin
                r_out_idx   <= table_full ? '0 : cnt_ext[IDX_OUT_W-1:0];
                r_out_found <= !table_full;
                r_out_rej   <= table_full;
            end else begin
                r_out_idx   <= '0;
                r_out_found <= 1'b0;
                r_out_rej   <= 1'b0;
            end
        end else if (d_ctl.valid && d_ctl.last) begin
            r_out_idx   <= idx_ext[IDX_OUT_W-1:0];
            r_out_found <= 1'b1;
            r_out_rej   <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_idx;
    assign o_m_axis_tuser  = {r_out_rej, r_out_found};

    // Checks on the block's own control.
    `NPS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_POINTS), "point count exceeds table size")
    `NPS_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, add_ok, r_count == $past(r_count) + CNT_W'(1), "point count did not advance on add")
    `NPS_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, o_m_axis_tvalid, !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "found and rejected both set")
    `NPS_ASSERT_SAME(a_busy_no_take, i_clk, i_rst_n, r_state != ST_IDLE, !o_s_axis_tready, "input accepted during a scan")

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Nearest point search testbench
// Streams add and query words into the point table. A shadow table in the
// bench predicts the index, found and rejected flags of every result word,
// and the results are compared in order. The stimulus starts with boundary
// coordinates, an empty-table query and distance ties. It then adds random
// points until the table is full and keeps adding, so that refused adds
// occur. Queries land on, near or far from stored points. Both stream sides
// insert random gaps, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import nps_pkg::*;

    localparam int TABLE_DEPTH  = MAX_POINTS_DEF;
    localparam int RANDOM_ITEMS = 930;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        t_kind                   kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_point_item;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] point_index;
        logic                 found;
        logic                 rejected;
    } t_search_result;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    // pos_x [15:0], pos_y [31:16], pos_z [47:32]
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // kind [0]
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    // point_index [7:0]
    logic [M_TDATA_W-1:0] m_tdata;
    // found [0], rejected [1]
    logic [M_TUSER_W-1:0] m_tuser;

    t_point_item    pending_words[$];
    t_point_item    shadow_points[$];
    t_search_result nearest_expected[$];
    t_point_item    on_offer;
    t_search_result want_res;

    // Shadow copy of the point table used for prediction.
    logic signed [POS_W-1:0] table_x[TABLE_DEPTH];
    logic signed [POS_W-1:0] table_y[TABLE_DEPTH];
    logic signed [POS_W-1:0] table_z[TABLE_DEPTH];
    int table_count = 0;

    int words_in       = 0;
    int words_out      = 0;
    int send_gap       = 0;
    int recv_stall     = 0;
    int idle_cycles    = 0;
    int mismatches     = 0;
    bit long_hold_done = 1'b0;

    nearest_point_search dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Squared difference along one axis, exact in 64 bits.
    function automatic longint axis_sq(logic signed [POS_W-1:0] a, logic signed [POS_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    // Applies one word to the shadow table and returns the result it causes.
    function automatic t_search_result predict_nearest(t_point_item it);
        t_search_result res;
        longint         best;
        longint         sum_sq;
        res  = '0;
        best = 0;
        if (it.kind == KIND_ADD) begin
            if (table_count >= TABLE_DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                table_x[table_count] = it.x;
                table_y[table_count] = it.y;
                table_z[table_count] = it.z;
                res.point_index = IDX_OUT_W'(table_count);
                res.found       = 1'b1;
                table_count++;
            end
        end else begin
            // Strict compare keeps the lower index on a tie.
            for (int i = 0; i < table_count; i++) begin
                sum_sq = axis_sq(table_x[i], it.x) + axis_sq(table_y[i], it.y)
                       + axis_sq(table_z[i], it.z);
                if (!res.found || sum_sq < best) begin
                    best            = sum_sq;
                    res.point_index = IDX_OUT_W'(i);
                    res.found       = 1'b1;
                end
            end
        end
        return res;
    endfunction

    task automatic queue_word(t_kind k, logic signed [POS_W-1:0] x,
                              logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
        t_point_item it;
        it.kind = k;
        it.x    = x;
        it.y    = y;
        it.z    = z;
        pending_words = {pending_words, it};
        if (k == KIND_ADD && shadow_points.size() < TABLE_DEPTH) begin
            shadow_points = {shadow_points, it};
        end
    endtask

    // Mostly full-range values, with extremes and a narrow band for ties.
    function automatic logic signed [POS_W-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'h7FFF;
        if (r < 6) return 16'h8000;
        if (r < 8) return 16'h0000;
        if (r < 10) return 16'hFFFF;
        if (r < 40) return POS_W'($urandom_range(0, 16)) - 16'sd8;
        return POS_W'($urandom);
    endfunction

    function automatic logic signed [POS_W-1:0] near_coord(logic signed [POS_W-1:0] c);
        return c + POS_W'($urandom_range(0, 6)) - 16'sd3;
    endfunction

    // Every fourth stretch of 64 words runs without any idling.
    function automatic bit quiet_stretch(int count);
        return ((count / 64) % 4) == 1;
    endfunction

    function automatic int pick_gap(int count);
        int r;
        if (quiet_stretch(count)) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want_v);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want_v);
        mismatches++;
    endtask

    // Driver: offers pending words and predicts each one as it is accepted.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                nearest_expected = {nearest_expected, predict_nearest(on_offer)};
                words_in <= words_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    on_offer = pending_words.pop_front();
                    s_tdata  <= {on_offer.z, on_offer.y, on_offer.x};
                    s_tuser  <= on_offer.kind;
                    s_valid  <= 1'b1;
                    send_gap <= pick_gap(words_in);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus one long hold that backs up the input.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready    <= 1'b0;
            recv_stall <= 0;
        end else if (recv_stall > 0) begin
            m_ready    <= 1'b0;
            recv_stall <= recv_stall - 1;
        end else if (!long_hold_done && words_out >= 40) begin
            long_hold_done <= 1'b1;
            recv_stall     <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (!m_ready || quiet_stretch(words_out) || $urandom_range(0, 2) != 0) begin
            m_ready <= 1'b1;
        end else begin
            recv_stall <= pick_gap(words_out);
            m_ready    <= 1'b0;
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            words_out <= words_out + 1;
            if (nearest_expected.size() == 0) begin
                report_mismatch("result word with no prediction, index", m_tdata, 0);
            end else begin
                want_res = nearest_expected.pop_front();
                if (m_tdata !== want_res.point_index) begin
                    report_mismatch("point_index", m_tdata, want_res.point_index);
                end
                if (m_tuser[0] !== want_res.found) begin
                    report_mismatch("found", m_tuser[0], want_res.found);
                end
                if (m_tuser[1] !== want_res.rejected) begin
                    report_mismatch("rejected", m_tuser[1], want_res.rejected);
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          r;
        int          add_odds;
        int          pick;
        t_point_item p;

        // Directed words: empty table, coordinate extremes and distance ties.
        queue_word(KIND_QUERY, 16'sd0, 16'sd0, 16'sd0);
        queue_word(KIND_ADD, 16'sd0, 16'sd0, 16'sd0);
        queue_word(KIND_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_word(KIND_ADD, 16'h8000, 16'h8000, 16'h8000);
        queue_word(KIND_QUERY, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_word(KIND_QUERY, 16'h8000, 16'h8000, 16'h8000);
        queue_word(KIND_ADD, 16'sd0, 16'sd0, 16'sd0);
        queue_word(KIND_QUERY, 16'sd1, 16'sd0, 16'sd0);
        queue_word(KIND_ADD, 16'sd2, 16'sd0, 16'sd0);
        queue_word(KIND_QUERY, 16'sd1, 16'sd0, 16'sd0);
        queue_word(KIND_ADD, 16'h8000, 16'h7FFF, 16'h8000);
        queue_word(KIND_ADD, 16'h7FFF, 16'h8000, 16'h7FFF);
        queue_word(KIND_QUERY, 16'h7FFF, 16'h8000, 16'sd0);
        queue_word(KIND_QUERY, 16'h8000, 16'h7FFF, 16'h7FFF);
        queue_word(KIND_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_word(KIND_QUERY, 16'sd0, 16'sd1, 16'sd0);
        queue_word(KIND_QUERY, 16'h4000, 16'h4000, 16'h4000);
        queue_word(KIND_QUERY, 16'hC000, 16'hC000, 16'hC000);

        // Random words: fill the table, then keep adding so adds are refused.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r        = $urandom_range(0, 99);
            add_odds = (shadow_points.size() < TABLE_DEPTH) ? 45 : 15;
            pick     = $urandom_range(0, shadow_points.size() - 1);
            p        = shadow_points[pick];
            if (r < add_odds) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_word(KIND_ADD, p.x, p.y, p.z);
                end else begin
                    queue_word(KIND_ADD, pick_coord(), pick_coord(), pick_coord());
                end
            end else begin
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    queue_word(KIND_QUERY, p.x, p.y, p.z);
                end else if (r < 6) begin
                    queue_word(KIND_QUERY, near_coord(p.x), near_coord(p.y), near_coord(p.z));
                end else begin
                    queue_word(KIND_QUERY, pick_coord(), pick_coord(), pick_coord());
                end
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (pending_words.size() != 0 || s_valid || nearest_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
